>>> hw/rtl/qtpm_pkg.sv
// ----------------------------------------------------------------------------
// qtpm_pkg: shared types and constants for the quadrant tile pixel mapper
// Holds sequencer states, register indexes, rotation codes, quadrant codes
// and the helper functions that clean up the tile side and rotation registers.
// ----------------------------------------------------------------------------
package qtpm_pkg;

  // Tile geometry and packet layout
  localparam int MAX_TILE_SIDE = 64;
  localparam int PACKET_BYTES  = 512;
  localparam int HEADER_BYTES  = 21;
  localparam int DEST_STEP     = 3;

  // Rotation angles in degrees
  localparam int ROT_FULL   = 360;
  localparam int ROT_DEG_90  = 90;
  localparam int ROT_DEG_180 = 180;
  localparam int ROT_DEG_270 = 270;

  // Field widths
  localparam int SIDE_W  = 7;   // tile side register
  localparam int DIM_W   = 13;  // source sizes, video rectangle
  localparam int WALK_W  = 8;   // signed walk coordinates and limits
  localparam int COORD_W = 10;  // signed multiplier coordinate operand
  localparam int POS_W   = 22;  // signed source position
  localparam int SRC_W   = 26;  // source byte offset
  localparam int DEST_W  = 15;  // packet byte offset
  localparam int MUL_A_W = 27;
  localparam int MUL_B_W = 14;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_X,
    ST_DIV_Y,
    ST_START_OUT,
    ST_MUL_X,
    ST_MUL_Y,
    ST_BOUND,
    ST_MUL_ROW,
    ST_MUL_CH,
    ST_PIX_OUT
  } state_t;

  typedef enum logic [2:0] {
    REG_TILE_WIDTH    = 3'd0,
    REG_TILE_HEIGHT   = 3'd1,
    REG_VIDEO_X       = 3'd2,
    REG_VIDEO_Y       = 3'd3,
    REG_VIDEO_W       = 3'd4,
    REG_VIDEO_H       = 3'd5,
    REG_ROTATION_DEG  = 3'd6,
    REG_START_CHANNEL = 3'd7
  } cfg_reg_t;

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_PIXEL = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ROT_0,
    ROT_90,
    ROT_180,
    ROT_270
  } rot_t;

  typedef enum logic [1:0] {
    QUAD_UPPER_LEFT,
    QUAD_LOWER_LEFT,
    QUAD_LOWER_RIGHT,
    QUAD_UPPER_RIGHT
  } quad_t;

  // Force the side even, then clamp it to the legal range
  function automatic logic [SIDE_W-1:0] side_of(input logic [SIDE_W-1:0] reg_val);
    logic [SIDE_W-1:0] v;
    v = {reg_val[SIDE_W-1:1], 1'b0};
    if (v > SIDE_W'(MAX_TILE_SIDE)) v = SIDE_W'(MAX_TILE_SIDE);
    if (v < SIDE_W'(2)) v = SIDE_W'(2);
    return v;
  endfunction

  // Reduce the angle into one turn; anything off the right angles is upright
  function automatic rot_t rot_code(input logic [8:0] deg);
    logic [8:0] r;
    rot_t     code;
    r = (deg >= 9'(ROT_FULL)) ? deg - 9'(ROT_FULL) : deg;
    case (r)
      9'(ROT_DEG_90):  code = ROT_90;
      9'(ROT_DEG_180): code = ROT_180;
      9'(ROT_DEG_270): code = ROT_270;
      default:         code = ROT_0;
    endcase
    return code;
  endfunction

endpackage

>>> hw/rtl/quadrant_tile_pixel_mapper_rotated_unit.sv
// Sequence: a pixel request with a live walk steps MUL_X, MUL_Y, BOUND, MUL_ROW, MUL_CH
// and PIX_OUT, skipping MUL_ROW and MUL_CH when the source pixel is out of bounds;
// start and idle requests load their result from IDLE. A start with a source attached
// runs two 13-step restoring divides. A new request is taken only in IDLE with the output
// register free, as the shared multiplier and divider are stepped by the sequencer.
// Reset (rst, synchronous, active high) restores the register defaults and idles the walk.
// ----------------------------------------------------------------------------
// quadrant_tile_pixel_mapper_rotated_unit: LED tile to video pixel mapper
// Walks the tile in quadrant order, turns it by 0, 90, 180 or 270 degrees and gives for
// each LED the source byte offset and the packet byte offset.
// ----------------------------------------------------------------------------
module quadrant_tile_pixel_mapper_rotated_unit
  import qtpm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data,
  // Request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // source_present, source_width[13], source_height[13],
                                // source_channels[3], zero fill
  input  logic        s_tuser,  // func
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,  // in_bounds, source_offset[26], dest_offset[15], zero fill
  output logic        m_tuser,  // pixel_valid
  output logic        m_tlast   // frame_last
);

  // Configuration registers
  logic [SIDE_W-1:0]        tile_width;
  logic [SIDE_W-1:0]        tile_height;
  logic signed [DIM_W-1:0]  video_x;
  logic signed [DIM_W-1:0]  video_y;
  logic [DIM_W-1:0]         video_w;
  logic [DIM_W-1:0]         video_h;
  logic [8:0]               rotation_deg;
  logic [4:0]               start_channel;

  // Walk state
  state_t                   state, state_next;
  logic                     walk_active;
  logic signed [WALK_W-1:0] walk_x, walk_y, row_limit, column_limit;
  quad_t                    quadrant_index;
  logic [DIM_W-1:0]         scale_x, scale_y;
  logic [DEST_W-1:0]        frame_offset;
  logic [DIM_W-1:0]         latched_width, latched_height;
  logic [2:0]               latched_channels;

  // Shared divider
  logic [SIDE_W-1:0]        div_den;
  logic [SIDE_W-1:0]        div_rem;
  logic [DIM_W-1:0]         div_q;
  logic [3:0]               div_cnt;
  logic [SIDE_W:0]          div_trial;
  logic                     div_ge;
  logic [SIDE_W-1:0]        div_rem_next;
  logic [DIM_W-1:0]         div_q_next;

  // Shared multiplier
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;

  // Source position
  logic signed [POS_W-1:0]  xx, yy, yy_now;
  logic                     in_bnd, in_bnd_now;
  logic [SRC_W-1:0]         row_sum;

  // Live geometry
  logic [SIDE_W-1:0]         w, h;
  logic signed [WALK_W-1:0]  w8, h8, hw8, hh8;
  logic signed [COORD_W-1:0] x_fwd, y_fwd, x_rev, y_rev;
  rot_t                      rot;
  logic [4:0]                ch_eff;

  // Walk stepping
  logic signed [WALK_W-1:0] wy_inc, wx_dec, wy_back;
  logic                     row_wrap, quad_end, frame_done;

  // Handshake and output control
  logic  s_accept, out_free;
  logic  out_load, out_pix, out_last;
  func_t req_func;
  logic  req_present;

  assign cfg_ready   = 1'b1;
  assign s_accept    = s_tvalid && s_tready;
  assign out_free    = !m_tvalid || m_tready;
  assign req_func    = func_t'(s_tuser);
  assign req_present = s_tdata[0];

  // Clean up the live registers
  assign w      = side_of(tile_width);
  assign h      = side_of(tile_height);
  assign w8     = $signed({1'b0, w});
  assign h8     = $signed({1'b0, h});
  assign hw8    = $signed({2'b00, w[SIDE_W-1:1]});
  assign hh8    = $signed({2'b00, h[SIDE_W-1:1]});
  assign rot    = rot_code(rotation_deg);
  assign ch_eff = (start_channel == 5'd0) ? 5'd1 : start_channel;

  // Forward and mirrored coordinates of the current LED
  assign x_fwd = $signed({{(COORD_W-WALK_W){walk_x[WALK_W-1]}}, walk_x});
  assign y_fwd = $signed({{(COORD_W-WALK_W){walk_y[WALK_W-1]}}, walk_y});
  assign x_rev = $signed({3'b000, w}) - x_fwd - 10'sd1;
  assign y_rev = $signed({3'b000, h}) - y_fwd - 10'sd1;

  // Restoring divide step: one quotient bit a cycle
  assign div_trial    = {div_rem, div_q[DIM_W-1]};
  assign div_ge       = div_trial >= {1'b0, div_den};
  assign div_rem_next = div_ge ? SIDE_W'(div_trial - {1'b0, div_den})
                               : div_trial[SIDE_W-1:0];
  assign div_q_next   = {div_q[DIM_W-2:0], div_ge};

  // Bounds check on the finished source position
  assign yy_now     = $signed({{(POS_W-DIM_W){video_y[DIM_W-1]}}, video_y})
                    + $signed(mul_p[POS_W-1:0]);
  assign in_bnd_now = !xx[POS_W-1] && (xx[POS_W-2:0] < {8'b0, latched_width})
                   && !yy_now[POS_W-1] && (yy_now[POS_W-2:0] < {8'b0, latched_height});
  assign row_sum    = {13'b0, xx[DIM_W-1:0]} + mul_p[SRC_W-1:0];

  // Next walk position
  assign wy_inc     = walk_y + 8'sd1;
  assign wx_dec     = walk_x - 8'sd1;
  assign wy_back    = row_limit - hh8;
  assign row_wrap   = wy_inc >= row_limit;
  assign quad_end   = wx_dec <= column_limit;
  assign frame_done = row_wrap && quad_end && (quadrant_index == QUAD_UPPER_RIGHT);

  // Select multiplier operands for the current step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_MUL_X: begin
        case (rot)
          ROT_90:  begin mul_a = MUL_A_W'(y_rev); mul_b = $signed({1'b0, scale_y}); end
          ROT_180: begin mul_a = MUL_A_W'(x_rev); mul_b = $signed({1'b0, scale_x}); end
          ROT_270: begin mul_a = MUL_A_W'(y_fwd); mul_b = $signed({1'b0, scale_y}); end
          default: begin mul_a = MUL_A_W'(x_fwd); mul_b = $signed({1'b0, scale_x}); end
        endcase
      end
      ST_MUL_Y: begin
        case (rot)
          ROT_90:  begin mul_a = MUL_A_W'(x_fwd); mul_b = $signed({1'b0, scale_x}); end
          ROT_180: begin mul_a = MUL_A_W'(y_fwd); mul_b = $signed({1'b0, scale_y}); end
          ROT_270: begin mul_a = MUL_A_W'(x_rev); mul_b = $signed({1'b0, scale_x}); end
          default: begin mul_a = MUL_A_W'(y_rev); mul_b = $signed({1'b0, scale_y}); end
        endcase
      end
      ST_MUL_ROW: begin
        mul_a = $signed({14'b0, yy[DIM_W-1:0]});
        mul_b = $signed({1'b0, latched_width});
      end
      ST_MUL_CH: begin
        mul_a = $signed({1'b0, row_sum});
        mul_b = $signed({11'b0, latched_channels});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Register every product
  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  // Sequencer: next state and output load
  always_comb begin
    state_next = state;
    s_tready   = (state == ST_IDLE) && out_free;
    out_load   = 1'b0;
    out_pix    = 1'b0;
    out_last   = 1'b1;
    case (state)
      ST_IDLE: begin
        if (s_accept) begin
          if (req_func == FUNC_START) begin
            if (req_present) begin
              state_next = ST_DIV_X;
            end else begin
              out_load = 1'b1;
            end
          end else if (walk_active) begin
            state_next = ST_MUL_X;
          end else begin
            out_load = 1'b1;
          end
        end
      end
      ST_DIV_X: begin
        if (div_cnt == 4'd0) state_next = ST_DIV_Y;
      end
      ST_DIV_Y: begin
        if (div_cnt == 4'd0) state_next = ST_START_OUT;
      end
      ST_START_OUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_last   = 1'b0;
          state_next = ST_IDLE;
        end
      end
      ST_MUL_X:   state_next = ST_MUL_Y;
      ST_MUL_Y:   state_next = ST_BOUND;
      ST_BOUND:   state_next = in_bnd_now ? ST_MUL_ROW : ST_PIX_OUT;
      ST_MUL_ROW: state_next = ST_MUL_CH;
      ST_MUL_CH:  state_next = ST_PIX_OUT;
      ST_PIX_OUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_pix    = 1'b1;
          out_last   = frame_done;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tile_width    <= SIDE_W'(8);
      tile_height   <= SIDE_W'(8);
      video_x       <= '0;
      video_y       <= '0;
      video_w       <= DIM_W'(8);
      video_h       <= DIM_W'(8);
      rotation_deg  <= '0;
      start_channel <= 5'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_TILE_WIDTH:    tile_width    <= cfg_data[SIDE_W-1:0];
        REG_TILE_HEIGHT:   tile_height   <= cfg_data[SIDE_W-1:0];
        REG_VIDEO_X:       video_x       <= $signed(cfg_data);
        REG_VIDEO_Y:       video_y       <= $signed(cfg_data);
        REG_VIDEO_W:       video_w       <= cfg_data;
        REG_VIDEO_H:       video_h       <= cfg_data;
        REG_ROTATION_DEG:  rotation_deg  <= cfg_data[8:0];
        REG_START_CHANNEL: start_channel <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Divider: load on start, step through both scale factors
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_accept && req_func == FUNC_START) begin
      div_q   <= video_w;
      div_rem <= '0;
      div_den <= w;
      div_cnt <= 4'(DIM_W - 1);
    end else if (state == ST_DIV_X && div_cnt == 4'd0) begin
      div_q   <= video_h;
      div_rem <= '0;
      div_den <= h;
      div_cnt <= 4'(DIM_W - 1);
    end else if (state == ST_DIV_X || state == ST_DIV_Y) begin
      div_q   <= div_q_next;
      div_rem <= div_rem_next;
      div_cnt <= div_cnt - 4'd1;
    end
  end

  // Source position and bounds flag
  always_ff @(posedge clk) begin
    if (state == ST_MUL_Y) begin
      xx <= $signed({{(POS_W-DIM_W){video_x[DIM_W-1]}}, video_x})
          + $signed(mul_p[POS_W-1:0]);
    end
    if (state == ST_BOUND) begin
      yy     <= yy_now;
      in_bnd <= in_bnd_now;
    end
  end

  // Frame state: latch the source, set up and advance the walk
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_active      <= 1'b0;
      walk_x           <= '0;
      walk_y           <= '0;
      row_limit        <= '0;
      column_limit     <= -8'sd1;
      quadrant_index   <= QUAD_UPPER_LEFT;
      scale_x          <= '0;
      scale_y          <= '0;
      frame_offset     <= '0;
      latched_width    <= '0;
      latched_height   <= '0;
      latched_channels <= '0;
    end else begin
      // Latch source geometry on every start; drop the walk if no source
      if (state == ST_IDLE && s_accept && req_func == FUNC_START) begin
        latched_width    <= s_tdata[13:1];
        latched_height   <= s_tdata[26:14];
        latched_channels <= s_tdata[29:27];
        if (!req_present) walk_active <= 1'b0;
      end
      if (state == ST_DIV_X && div_cnt == 4'd0) begin
        scale_x <= div_q_next;
      end
      // Begin the walk once both factors are in
      if (state == ST_DIV_Y && div_cnt == 4'd0) begin
        scale_y        <= div_q_next;
        walk_x         <= hw8 - 8'sd1;
        walk_y         <= '0;
        quadrant_index <= QUAD_UPPER_LEFT;
        row_limit      <= hh8;
        column_limit   <= -8'sd1;
        frame_offset   <= DEST_W'(PACKET_BYTES * int'(ch_eff - 5'd1) + HEADER_BYTES);
        walk_active    <= 1'b1;
      end
      // Advance one LED after its result goes out
      if (state == ST_PIX_OUT && out_free) begin
        frame_offset <= frame_offset + DEST_W'(DEST_STEP);
        if (!row_wrap) begin
          walk_y <= wy_inc;
        end else if (!quad_end) begin
          walk_x <= wx_dec;
          walk_y <= wy_back;
        end else begin
          case (quadrant_index)
            QUAD_UPPER_LEFT: begin
              quadrant_index <= QUAD_LOWER_LEFT;
              walk_x         <= hw8 - 8'sd1;
              walk_y         <= hh8;
              row_limit      <= h8;
            end
            QUAD_LOWER_LEFT: begin
              quadrant_index <= QUAD_LOWER_RIGHT;
              walk_x         <= w8 - 8'sd1;
              walk_y         <= hh8;
              column_limit   <= hw8 - 8'sd1;
            end
            QUAD_LOWER_RIGHT: begin
              quadrant_index <= QUAD_UPPER_RIGHT;
              walk_x         <= w8 - 8'sd1;
              walk_y         <= '0;
              row_limit      <= hh8;
            end
            default: begin
              walk_x      <= wx_dec;
              walk_y      <= wy_back;
              walk_active <= 1'b0;
            end
          endcase
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser <= out_pix;
      m_tlast <= out_last;
      if (out_pix) begin
        m_tdata <= {6'b0, frame_offset,
                    (in_bnd ? mul_p[SRC_W-1:0] : {SRC_W{1'b0}}), in_bnd};
      end else begin
        m_tdata <= '0;
      end
    end
  end

`ifndef SYNTHESIS
  // An in-bounds flag only ever rides on a pixel result
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tuser)
    else $error("in_bounds set on a non-pixel result");

  // A walk only begins at the end of the scale divide
  assert property (@(posedge clk) disable iff (rst)
    $rose(walk_active) |-> state == ST_START_OUT)
    else $error("walk started outside the divide sequence");

  // The walk stays live while a pixel is being mapped
  assert property (@(posedge clk) disable iff (rst)
    state == ST_PIX_OUT |-> walk_active)
    else $error("pixel mapped with no active walk");
`endif

endmodule
